>>> src/llc_pkg.sv
// ----------------------------------------------------------------------------
// llc_pkg
// Shared constants, operand tables and types for the live-wire link cost block.
// ----------------------------------------------------------------------------
package llc_pkg;

    localparam int unsigned NBR        = 8;
    localparam int unsigned PIX_W      = 24;
    localparam int unsigned COST_W     = 16;
    localparam int unsigned CFG_W      = 16;
    localparam int unsigned DQ_W       = 24;
    localparam int unsigned SUM_W      = 50;
    localparam int unsigned ISQ_STEPS  = SUM_W / 2;
    localparam int unsigned ROOT_W     = ISQ_STEPS;
    localparam int unsigned TAB_AW     = 12;
    localparam int unsigned TAB_DEPTH  = 1 << TAB_AW;
    localparam int unsigned LAT        = 8 + ISQ_STEPS;
    localparam int unsigned IN_W       = NBR * PIX_W + NBR;
    localparam int unsigned OUT_W      = NBR * COST_W;

    localparam logic [23:0] FULL_Q8    = 24'd65280;
    localparam logic [24:0] HALF_Q8    = 25'd32640;
    localparam logic [15:0] INV_SQRT2  = 16'd46341;
    localparam logic [31:0] EXP_STEP   = 32'd4278222805;
    localparam logic [25:0] RECIP3     = 26'd44739243;
    localparam int unsigned RECIP3_SH  = 27;

    localparam logic [2:0] OPND [0:7][0:3] = '{
        '{3'd2, 3'd1, 3'd6, 3'd7}, '{3'd2, 3'd0, 3'd0, 3'd0},
        '{3'd3, 3'd4, 3'd1, 3'd0}, '{3'd2, 3'd4, 3'd0, 3'd0},
        '{3'd3, 3'd2, 3'd5, 3'd6}, '{3'd6, 3'd4, 3'd0, 3'd0},
        '{3'd4, 3'd5, 3'd0, 3'd7}, '{3'd6, 3'd0, 3'd0, 3'd0}
    };

    localparam logic [7:0] NEED_MASK [0:7] = '{
        8'hC7, 8'h07, 8'h1F, 8'h1C, 8'h7C, 8'h70, 8'hF1, 8'hC1
    };

    typedef struct packed {
        logic              en;
        logic [TAB_AW-1:0] addr;
        logic [COST_W-1:0] data;
    } t_fill_wr;

endpackage

>>> src/llc_exp_fill.sv
// ----------------------------------------------------------------------------
// llc_exp_fill
// Builds the sigmoid table after reset: exp steps by repeated Q32 multiply,
// one restoring division per entry.
// ----------------------------------------------------------------------------
module llc_exp_fill (
    input  logic              i_clk,
    input  logic              i_rst_n,
    output llc_pkg::t_fill_wr o_wr,
    output logic              o_done
);

    typedef enum logic [1:0] {ST_MUL, ST_DIV, ST_NEXT, ST_DONE} t_state;

    t_state                        r_state;
    logic [31:0]                   r_e;
    logic [llc_pkg::TAB_AW-1:0]    r_idx;
    logic [32:0]                   r_div;
    logic [32:0]                   r_rem;
    logic [15:0]                   r_lo;
    logic [15:0]                   r_q;
    logic [3:0]                    r_cnt;
    llc_pkg::t_fill_wr             r_wr;
    logic                          r_done;

    logic [32:0]                   n_div;
    logic [47:0]                   n_num;
    logic [63:0]                   n_prod;
    logic [33:0]                   n_rem2;
    logic                          n_qbit;

    always_comb begin
        n_div  = {1'b0, 32'h8000_0000} + {1'b0, r_e};
        n_num  = 48'(r_e) * 48'd65280 + 48'(n_div >> 1);
        n_prod = 64'(r_e) * 64'(llc_pkg::EXP_STEP) + 64'h8000_0000;
        n_rem2 = {r_rem, r_lo[15]};
        n_qbit = n_rem2 >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_MUL;
            r_e     <= 32'h8000_0000;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_wr    <= '0;
            r_done  <= 1'b0;
        end else begin
            case (r_state)
                ST_MUL: begin
                    r_div   <= n_div;
                    r_rem   <= {1'b0, n_num[47:16]};
                    r_lo    <= n_num[15:0];
                    r_e     <= n_prod[63:32];
                    r_cnt   <= 4'd15;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_rem <= n_qbit ? 33'(n_rem2 - {1'b0, r_div}) : n_rem2[32:0];
                    r_lo  <= {r_lo[14:0], 1'b0};
                    r_q   <= {r_q[14:0], n_qbit};
                    r_cnt <= r_cnt - 4'd1;
                    if (r_cnt == 4'd0) begin
                        r_wr.en   <= 1'b1;
                        r_wr.addr <= r_idx;
                        r_wr.data <= {r_q[14:0], n_qbit};
                        r_state   <= ST_NEXT;
                    end
                end
                ST_NEXT: begin
                    r_wr.en <= 1'b0;
                    if (r_idx == {llc_pkg::TAB_AW{1'b1}}) begin
                        r_done  <= 1'b1;
                        r_state <= ST_DONE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= ST_MUL;
                    end
                end
                default: begin
                    r_wr.en <= 1'b0;
                end
            endcase
        end
    end

    assign o_wr   = r_wr;
    assign o_done = r_done;

endmodule

>>> src/llc_lane.sv
// ----------------------------------------------------------------------------
// llc_lane
// One link direction: derivative, squared norm, pipelined square root,
// divide by three and sigmoid lookup.
// ----------------------------------------------------------------------------
module llc_lane (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [3:0][llc_pkg::PIX_W-1:0] i_opnd,
    input  logic                           i_diag,
    input  logic                           i_ok,
    input  logic [llc_pkg::CFG_W-1:0]      i_absent,
    input  llc_pkg::t_fill_wr              i_wr,
    output logic [llc_pkg::COST_W-1:0]     o_cost
);

    localparam int unsigned RW = llc_pkg::ROOT_W;

    logic [llc_pkg::DQ_W-1:0]     r_dq  [0:2];
    logic [llc_pkg::DQ_W-1:0]     r_mag [0:2];
    logic [2*llc_pkg::DQ_W-1:0]   r_sq  [0:2];
    logic [llc_pkg::SUM_W-1:0]    r_sum;
    logic [RW:0]                  s_rem  [0:llc_pkg::ISQ_STEPS];
    logic [RW-1:0]                s_root [0:llc_pkg::ISQ_STEPS];
    logic [llc_pkg::SUM_W-1:0]    s_rad  [0:llc_pkg::ISQ_STEPS];
    logic [23:0]                  r_d;
    logic                         r_neg;
    logic                         r_big;
    logic [llc_pkg::TAB_AW-1:0]   r_addr;
    logic                         r_neg2;
    logic                         r_big2;
    logic [llc_pkg::COST_W-1:0]   r_f;
    logic [llc_pkg::COST_W-1:0]   r_cost;
    logic [llc_pkg::COST_W-1:0]   r_tab [0:llc_pkg::TAB_DEPTH-1];

    logic [2*RW:0]                n_prod3;
    logic [24:0]                  n_x;

    for (genvar c = 0; c < 3; c++) begin : g_ch
        logic [7:0]  w_a, w_b, w_c, w_d;
        logic [8:0]  w_l, w_r;
        logic [8:0]  w_sd;
        logic [7:0]  w_ad;
        logic [23:0] w_dg;
        logic [llc_pkg::DQ_W-1:0] w_dq;

        assign w_a  = i_opnd[0][8*c +: 8];
        assign w_b  = i_opnd[1][8*c +: 8];
        assign w_c  = i_opnd[2][8*c +: 8];
        assign w_d  = i_opnd[3][8*c +: 8];
        assign w_l  = ({1'b0, w_a} + {1'b0, w_b}) >> 1;
        assign w_r  = ({1'b0, w_c} + {1'b0, w_d}) >> 1;
        assign w_sd = i_diag ? {1'b0, w_a} - {1'b0, w_b} : w_l - w_r;
        assign w_ad = w_sd[8] ? 8'(-w_sd) : w_sd[7:0];
        assign w_dg = 24'(w_ad) * 24'(llc_pkg::INV_SQRT2) + 24'd128;

        always_comb begin
            if (!i_ok) begin
                w_dq = {i_absent, 8'd0};
            end else if (i_diag) begin
                w_dq = {8'd0, w_dg[23:8]};
            end else begin
                w_dq = {9'd0, w_ad[7:1], 8'd0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dq[c]  <= w_dq;
                r_mag[c] <= (r_dq[c] > llc_pkg::FULL_Q8) ? r_dq[c] - llc_pkg::FULL_Q8
                                                         : llc_pkg::FULL_Q8 - r_dq[c];
                r_sq[c]  <= 48'(r_mag[c]) * 48'(r_mag[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= 50'(r_sq[0]) + 50'(r_sq[1]) + 50'(r_sq[2]);
        end
    end

    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_rad[0]  = r_sum;

    for (genvar i = 0; i < llc_pkg::ISQ_STEPS; i++) begin : g_isq
        logic [RW+2:0] w_rem2;
        logic [RW+2:0] w_trial;
        logic          w_ge;
        logic [RW:0]   r_rem;
        logic [RW-1:0] r_root;
        logic [llc_pkg::SUM_W-1:0] r_rad;

        assign w_rem2  = {s_rem[i], s_rad[i][llc_pkg::SUM_W-1 -: 2]};
        assign w_trial = {1'b0, s_root[i], 2'b01};
        assign w_ge    = w_rem2 >= w_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= w_ge ? (RW+1)'(w_rem2 - w_trial) : w_rem2[RW:0];
                r_root <= {s_root[i][RW-2:0], w_ge};
                r_rad  <= {s_rad[i][llc_pkg::SUM_W-3:0], 2'b00};
            end
        end

        assign s_rem[i+1]  = r_rem;
        assign s_root[i+1] = r_root;
        assign s_rad[i+1]  = r_rad;
    end

    assign n_prod3 = (2*RW+1)'(s_root[llc_pkg::ISQ_STEPS]) * (2*RW+1)'(llc_pkg::RECIP3);
    assign n_x     = {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_tab[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d    <= n_prod3[llc_pkg::RECIP3_SH +: 24];
            r_neg  <= n_x > llc_pkg::HALF_Q8;
            r_big  <= ((n_x > llc_pkg::HALF_Q8) ? n_x - llc_pkg::HALF_Q8
                                                : llc_pkg::HALF_Q8 - n_x)
                      >= 25'(llc_pkg::TAB_DEPTH);
            r_addr <= llc_pkg::TAB_AW'((n_x > llc_pkg::HALF_Q8) ? n_x - llc_pkg::HALF_Q8
                                                                : llc_pkg::HALF_Q8 - n_x);
            r_f    <= r_tab[r_addr];
            r_neg2 <= r_neg;
            r_big2 <= r_big;
            if (r_big2) begin
                r_cost <= r_neg2 ? llc_pkg::FULL_Q8[15:0] : '0;
            end else begin
                r_cost <= r_neg2 ? llc_pkg::FULL_Q8[15:0] - r_f : r_f;
            end
        end
    end

    assign o_cost = r_cost;

endmodule

>>> src/livewire_link_cost.sv
// ----------------------------------------------------------------------------
// livewire_link_cost
// Eight live-wire link costs for one pixel neighbourhood per request.
// ----------------------------------------------------------------------------
// Pipeline: each lane holds a 25-stage square root. Throughput: one request per
// cycle while the output is not stalled (m_axis_tvalid high, m_axis_tready low).
// Reset: synchronous, active low. After reset the sigmoid table is built, all
// 4096 entries; input is held off meanwhile.
module livewire_link_cost (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [llc_pkg::CFG_W-1:0]   i_cfg_wdata,  // absent_link_derivative
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // east_rgb, northeast_rgb, north_rgb, northwest_rgb, west_rgb,
    // southwest_rgb, south_rgb, southeast_rgb, neighbour_present
    input  logic [llc_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // cost_east, cost_northeast, cost_north, cost_northwest, cost_west,
    // cost_southwest, cost_south, cost_southeast
    output logic [llc_pkg::OUT_W-1:0]   m_axis_tdata
);

    logic [llc_pkg::CFG_W-1:0]  r_absent;
    logic [llc_pkg::LAT-1:0]    r_vld;
    llc_pkg::t_fill_wr          w_wr;
    logic                       w_done;
    logic                       w_en;
    logic [7:0]                 w_present;

    assign w_en          = !r_vld[llc_pkg::LAT-1] || m_axis_tready;
    assign s_axis_tready = w_done && w_en;
    assign m_axis_tvalid = r_vld[llc_pkg::LAT-1];
    assign w_present     = s_axis_tdata[llc_pkg::NBR*llc_pkg::PIX_W +: 8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_absent <= '1;
            r_vld    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_absent <= i_cfg_wdata;
            end
            if (w_en) begin
                r_vld <= {r_vld[llc_pkg::LAT-2:0], s_axis_tvalid && s_axis_tready};
            end
        end
    end

    llc_exp_fill u_fill (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_wr    (w_wr),
        .o_done  (w_done)
    );

    for (genvar k = 0; k < llc_pkg::NBR; k++) begin : g_lane
        logic [3:0][llc_pkg::PIX_W-1:0] w_opnd;

        for (genvar j = 0; j < 4; j++) begin : g_op
            assign w_opnd[j] =
                s_axis_tdata[llc_pkg::PIX_W*llc_pkg::OPND[k][j] +: llc_pkg::PIX_W];
        end

        llc_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_opnd   (w_opnd),
            .i_diag   ((k % 2) == 1),
            .i_ok     ((w_present & llc_pkg::NEED_MASK[k]) == llc_pkg::NEED_MASK[k]),
            .i_absent (r_absent),
            .i_wr     (w_wr),
            .o_cost   (m_axis_tdata[llc_pkg::COST_W*k +: llc_pkg::COST_W])
        );
    end

endmodule

>>> bench/llc_cost_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// llc_cost_checker
// Watches the request and result channels of the link cost block, computes
// the eight expected link costs of every accepted request and compares them
// with the results in order.
// ----------------------------------------------------------------------------
module llc_cost_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [llc_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                      i_req_valid,
    input  logic                      i_req_ready,
    input  logic [llc_pkg::IN_W-1:0]  i_req_data,
    input  logic                      i_res_valid,
    input  logic                      i_res_ready,
    input  logic [llc_pkg::OUT_W-1:0] i_res_data,
    output int                        o_errors
);
    import llc_pkg::*;

    logic [63:0]       exp_tab [0:4095];
    logic [15:0]       absent_deriv;
    logic [OUT_W-1:0]  cost_q[$];

    initial begin
        logic [63:0] e;
        o_errors = 0;
        e = 64'd1 << 31;
        for (int i = 0; i < 4096; i++) begin
            exp_tab[i] = e;
            e = (e * 64'd4278222805 + (64'd1 << 31)) >> 32;
        end
    end

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] sigmoid(longint d);
        longint      x;
        longint      a;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] f;
        x = 32640 - d;
        a = (x < 0) ? -x : x;
        e = (a < 4096) ? exp_tab[a] : 64'd0;
        den = (64'd1 << 31) + e;
        f = (64'd65280 * e + den / 2) / den;
        return (x >= 0) ? f[15:0] : 16'(65280 - f);
    endfunction

    function automatic logic [OUT_W-1:0] link_costs(logic [IN_W-1:0] req,
                                                    logic [15:0] absent);
        logic [OUT_W-1:0] out;
        logic [7:0]       present;
        int               p [0:3];
        longint           dq;
        longint           em;
        longint           l;
        longint           r;
        logic [63:0]      sum;
        present = req[NBR*PIX_W +: 8];
        for (int k = 0; k < 8; k++) begin
            sum = 0;
            for (int c = 0; c < 3; c++) begin
                for (int j = 0; j < 4; j++)
                    p[j] = req[OPND[k][j]*PIX_W + 16 - 8*c +: 8];
                if ((present & NEED_MASK[k]) != NEED_MASK[k]) begin
                    dq = longint'(absent) * 256;
                end else if (k % 2 == 1) begin
                    l = (p[0] > p[1]) ? p[0] - p[1] : p[1] - p[0];
                    dq = (l * 46341 + 128) >>> 8;
                end else begin
                    l = (p[0] + p[1]) / 2;
                    r = (p[2] + p[3]) / 2;
                    dq = (((l > r) ? l - r : r - l) / 2) * 256;
                end
                em = 65280 - dq;
                if (em < 0) em = -em;
                sum = sum + em * em;
            end
            out[k*COST_W +: COST_W] = sigmoid(longint'(int_sqrt(sum) / 3));
        end
        return out;
    endfunction

    task automatic report(string what, int lane, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s lane %0d: got %0d expected %0d at %0t",
                 what, lane, got, want, $realtime);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        logic [OUT_W-1:0] want;
        if (!i_rst_n) begin
            absent_deriv <= 16'hFFFF;
        end else begin
            if (i_req_valid && i_req_ready)
                cost_q.push_back(link_costs(i_req_data, absent_deriv));
            if (i_res_valid && i_res_ready) begin
                if (cost_q.size() == 0) begin
                    report("unexpected result", -1, 0, 0);
                end else begin
                    want = cost_q.pop_front();
                    for (int k = 0; k < 8; k++)
                        if (i_res_data[k*COST_W +: COST_W] !== want[k*COST_W +: COST_W])
                            report("cost", k, i_res_data[k*COST_W +: COST_W],
                                   want[k*COST_W +: COST_W]);
                end
            end
            if (i_cfg_we)
                absent_deriv <= i_cfg_wdata;
        end
    end
endmodule

>>> bench/tb_livewire_link_cost.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_livewire_link_cost
// Drives pixel neighbourhoods and absent-link derivative settings into the
// link cost block with random gaps and stalls; a checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module tb_livewire_link_cost;
    import llc_pkg::*;

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_cfg_we = 0;
    logic [CFG_W-1:0]  i_cfg_wdata = 0;
    logic              s_axis_tvalid = 0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = 0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 0;
    logic [OUT_W-1:0]  m_axis_tdata;
    int                errors;
    int                n_sent = 0;
    int                n_recv = 0;
    bit                quiet = 0;
    bit                rx_hold = 0;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    livewire_link_cost DUT (.*);

    llc_cost_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_req_valid(s_axis_tvalid), .i_req_ready(s_axis_tready), .i_req_data(s_axis_tdata),
        .i_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready), .i_res_data(m_axis_tdata),
        .o_errors(errors)
    );

    always @(posedge i_clk)
        if (m_axis_tvalid && m_axis_tready) n_recv <= n_recv + 1;

    task automatic send_req(logic [IN_W-1:0] d);
        int gap;
        gap = (quiet || rx_hold) ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= d;
        s_axis_tvalid <= 1;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        n_sent++;
    endtask

    task automatic set_absent(logic [15:0] v);
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        wait (n_sent == n_recv);
        repeat (40) @(posedge i_clk);
        i_cfg_we    <= 1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 0;
    endtask

    function automatic logic [IN_W-1:0] flat(logic [23:0] px, logic [7:0] mask);
        return {mask, {NBR{px}}};
    endfunction

    function automatic logic [23:0] rand_px();
        case ($urandom_range(0, 5))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [IN_W-1:0] rand_req();
        logic [IN_W-1:0] d;
        logic [23:0]     base;
        base = 24'($urandom);
        for (int k = 0; k < 8; k++)
            d[k*PIX_W +: PIX_W] = ($urandom_range(0, 3) == 0) ?
                                  base ^ 24'($urandom_range(0, 7) * 24'h010101) : rand_px();
        d[NBR*PIX_W +: 8] = ($urandom_range(0, 2) != 0) ? 8'hFF : 8'($urandom);
        return d;
    endfunction

    initial begin
        logic [15:0] settings [0:5];
        logic [IN_W-1:0] d;
        settings = '{16'd0, 16'd255, 16'd256, 16'd1, 16'hFFFF, 16'h0000};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: flat fields, extremes, checkerboards, each neighbour absent
        send_req(flat(24'h000000, 8'hFF));
        send_req(flat(24'hFFFFFF, 8'hFF));
        send_req(flat(24'h000000, 8'h00));
        send_req({8'hFF, {4{24'h000000, 24'hFFFFFF}}});
        send_req({8'hFF, {4{24'hFFFFFF, 24'h000000}}});
        send_req({8'hFF, {2{24'hFF00FF, 24'h00FF00, 24'h000000, 24'hFFFFFF}}});
        for (int k = 0; k < 8; k++) begin
            d = rand_req();
            d[NBR*PIX_W +: 8] = ~(8'd1 << k);
            send_req(d);
        end
        for (int k = 0; k < 8; k++) begin
            d = rand_req();
            d[NBR*PIX_W +: 8] = 8'd1 << k;
            send_req(d);
        end

        for (int ph = 0; ph < 6; ph++) begin
            set_absent(settings[ph]);
            quiet = (ph == 2);
            for (int i = 0; i < 105; i++) begin
                if (ph == 3 && i == 20) rx_hold = 1;
                send_req(rand_req());
            end
        end
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        wait (n_sent == n_recv);
        repeat (40) @(posedge i_clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        int w;
        @(posedge i_rst_n);
        forever begin
            if (rx_hold) begin
                m_axis_tready <= 0;
                repeat (300) @(posedge i_clk);
                rx_hold = 0;
            end
            w = quiet ? 0 : $urandom_range(0, 11);
            if (w > 0) begin
                m_axis_tready <= 0;
                repeat (w) @(posedge i_clk);
            end
            m_axis_tready <= 1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    initial begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule

>>> files.f
src/llc_pkg.sv
src/llc_exp_fill.sv
src/llc_lane.sv
src/livewire_link_cost.sv
bench/llc_cost_checker.sv
bench/tb_livewire_link_cost.sv
